// File: hw/rtl/ssol_pkg.sv
// ----------------------------------------------------------------------------
// Span slot ownership ledger package
// Shared sizes, opcodes, the span record layout and the control/status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ssol_pkg;

  localparam int SPAN_COUNT     = 64;
  localparam int MAX_SLOTS      = 512;
  localparam int WORD_BITS      = 64;
  localparam int WORDS_PER_SPAN = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int TOTAL_WORDS    = SPAN_COUNT * WORDS_PER_SPAN;

  localparam int SPAN_W  = 6;
  localparam int SLOT_W  = 9;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WSEL_W  = $clog2(WORDS_PER_SPAN);
  localparam int WORD_AW = $clog2(TOTAL_WORDS);
  localparam int CAP_W   = 10;
  localparam int CNT_W   = 32;
  localparam int TOK_W   = 8;
  localparam int CLS_W   = 8;
  localparam int OP_W    = 3;

  localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd0;
  localparam logic [OP_W-1:0] OP_DRAIN   = 3'd1;
  localparam logic [OP_W-1:0] OP_RETURN  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
  localparam logic [OP_W-1:0] OP_RECYCLE = 3'd4;

  typedef struct packed {
    logic [TOK_W-1:0] owner_slot;
    logic [CNT_W-1:0] owner_gen;
    logic [CLS_W-1:0] tag;        // class + 1, zero when unbound
    logic [CAP_W-1:0] capacity;
    logic [CAP_W-1:0] carved;
    logic [CAP_W-1:0] outstanding;
    logic [CNT_W-1:0] drained;
    logic [CNT_W-1:0] rejected;
  } span_rec_t;

  typedef struct packed {
    logic               load;       // capture item, read record and word
    logic               wipe;       // zero one bitmap word, and one record unless wipe_span
    logic               wipe_span;  // wipe inside the latched span only
    logic [WORD_AW-1:0] wipe_idx;
    logic               commit;     // write back record and word
    logic               out_load;   // load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic recycle_ok;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/ssol_datapath.sv
// ----------------------------------------------------------------------------
// Span slot ownership ledger datapath
// Item registers, bitmap and span record memories, the transition logic
// and the result register.
// ----------------------------------------------------------------------------
module ssol_datapath
  import ssol_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  output dp_status_t           status,
  input  logic [OP_W-1:0]      opcode,
  input  logic [SPAN_W-1:0]    span_index,
  input  logic [SLOT_W-1:0]    slot_number,
  input  logic [CLS_W-1:0]     size_class,
  input  logic [TOK_W-1:0]     owner_slot,
  input  logic [CNT_W-1:0]     owner_generation,
  input  logic                 shadow_present,
  input  logic [TOK_W-1:0]     shadow_slot,
  input  logic [CNT_W-1:0]     shadow_generation,
  input  logic [CAP_W-1:0]     class_capacity,
  input  logic                 batch_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 accepted,
  output logic [CAP_W-1:0]     carved_count,
  output logic [CAP_W-1:0]     outstanding_count,
  output logic [CNT_W-1:0]     drained_count,
  output logic [CNT_W-1:0]     rejected_count,
  output logic [TOK_W-1:0]     bound_owner_slot,
  output logic [CNT_W-1:0]     bound_owner_generation,
  output logic [CLS_W-1:0]     bound_class,
  output logic                 span_full,
  output logic                 reuse_candidate,
  output logic                 last_of_batch
);

  logic [WORD_BITS-1:0] bmp_mem [TOTAL_WORDS];
  span_rec_t            rec_mem [SPAN_COUNT];

  // latched item
  logic [OP_W-1:0]   op_q;
  logic [SPAN_W-1:0] span_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CLS_W-1:0]  cls_q;
  logic [TOK_W-1:0]  oslot_q;
  logic [CNT_W-1:0]  ogen_q;
  logic              shadow_ok_q;
  logic [CAP_W-1:0]  cap_q;
  logic              batch_q;

  logic [WORD_BITS-1:0] word_q;
  span_rec_t            rec_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q        <= opcode;
      span_q      <= span_index;
      slot_q      <= slot_number;
      cls_q       <= size_class;
      oslot_q     <= owner_slot;
      ogen_q      <= owner_generation;
      shadow_ok_q <= shadow_present && shadow_slot == owner_slot &&
                     shadow_generation == owner_generation;
      cap_q       <= class_capacity;
      batch_q     <= batch_end;
      word_q      <= bmp_mem[{span_index, slot_number[SLOT_W-1:BIT_W]}];
      rec_q       <= rec_mem[span_index];
    end
  end

  // transition logic
  logic [WORD_AW-1:0]   word_addr;
  logic [BIT_W-1:0]     bit_sel;
  logic                 bit_set;
  logic [CLS_W-1:0]     tag_in;
  logic                 bind_ok;
  span_rec_t            rec_b;
  span_rec_t            rec_n;
  logic [WORD_BITS-1:0] word_n;
  logic                 bmp_we;
  logic                 rec_we;
  logic                 acc;
  logic [CAP_W-1:0]     slot_plus;
  logic                 full;

  assign word_addr = {span_q, slot_q[SLOT_W-1:BIT_W]};
  assign bit_sel   = slot_q[BIT_W-1:0];
  assign bit_set   = word_q[bit_sel];
  assign tag_in    = cls_q + CLS_W'(1);
  assign slot_plus = CAP_W'(slot_q) + CAP_W'(1);
  assign full      = rec_q.capacity != '0 && rec_q.carved == rec_q.capacity;

  always_comb begin
    rec_b   = rec_q;
    bind_ok = 1'b0;
    if (shadow_ok_q) begin
      if (rec_q.tag == '0) begin
        rec_b.owner_slot = oslot_q;
        rec_b.owner_gen  = ogen_q;
        rec_b.tag        = tag_in;
        rec_b.capacity   = cap_q;
        bind_ok          = 1'b1;
      end else begin
        bind_ok = rec_q.owner_slot == oslot_q && rec_q.owner_gen == ogen_q &&
                  rec_q.tag == tag_in;
      end
    end
  end

  always_comb begin
    rec_n  = rec_b;
    word_n = word_q;
    bmp_we = 1'b0;
    rec_we = 1'b0;
    acc    = 1'b0;
    case (op_q)
      OP_ACQUIRE: begin
        rec_we = 1'b1;
        if (!bind_ok || bit_set) begin
          rec_n.rejected = rec_b.rejected + CNT_W'(1);
        end else begin
          word_n[bit_sel]   = 1'b1;
          bmp_we            = 1'b1;
          if (rec_b.carved < slot_plus) rec_n.carved = slot_plus;
          rec_n.outstanding = rec_b.outstanding + CAP_W'(1);
          acc               = 1'b1;
        end
      end
      OP_DRAIN: begin
        rec_we = 1'b1;
        if (!bind_ok || !bit_set) begin
          rec_n.rejected = rec_b.rejected + CNT_W'(1);
        end else begin
          rec_n.drained = rec_b.drained + CNT_W'(1);
          acc           = 1'b1;
        end
      end
      OP_RETURN: begin
        rec_we = 1'b1;
        if (!bind_ok || !bit_set || rec_b.outstanding == '0) begin
          rec_n.rejected = rec_b.rejected + CNT_W'(1);
        end else begin
          word_n[bit_sel]   = 1'b0;
          bmp_we            = 1'b1;
          rec_n.outstanding = rec_b.outstanding - CAP_W'(1);
          acc               = 1'b1;
        end
      end
      OP_QUERY: begin
        acc = rec_q.tag != '0;
      end
      OP_RECYCLE: begin
        if (shadow_ok_q) begin
          rec_n            = '0;
          rec_n.owner_slot = oslot_q;
          rec_n.owner_gen  = ogen_q;
          rec_n.tag        = tag_in;
          rec_n.capacity   = cap_q;
          rec_we           = 1'b1;
          acc              = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // memory writes; a wipe outranks a commit
  logic [WORD_AW-1:0] wipe_addr;
  assign wipe_addr = cmd.wipe_span ? {span_q, cmd.wipe_idx[WSEL_W-1:0]} : cmd.wipe_idx;

  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      bmp_mem[wipe_addr] <= '0;
    end else if (cmd.commit && bmp_we) begin
      bmp_mem[word_addr] <= word_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wipe && !cmd.wipe_span) begin
      rec_mem[cmd.wipe_idx[SPAN_W-1:0]] <= '0;
    end else if (cmd.commit && rec_we) begin
      rec_mem[span_q] <= rec_n;
    end
  end

  // result register
  logic is_query;
  assign is_query = op_q == OP_QUERY && acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted               <= acc;
      last_of_batch          <= batch_q;
      carved_count           <= is_query ? rec_q.carved : '0;
      outstanding_count      <= is_query ? rec_q.outstanding : '0;
      drained_count          <= is_query ? rec_q.drained : '0;
      rejected_count         <= is_query ? rec_q.rejected : '0;
      bound_owner_slot       <= is_query ? rec_q.owner_slot : '0;
      bound_owner_generation <= is_query ? rec_q.owner_gen : '0;
      bound_class            <= is_query ? rec_q.tag - CLS_W'(1) : '0;
      span_full              <= is_query && full;
      reuse_candidate        <= is_query && full && rec_q.outstanding == '0 &&
                                rec_q.rejected == '0;
    end
  end

  assign status.recycle_ok = op_q == OP_RECYCLE && shadow_ok_q;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

// File: hw/rtl/ssol_ctrl.sv
// ----------------------------------------------------------------------------
// Span slot ownership ledger sequencer
// Clearing pass after reset, item capture, span wipe on recycle, write-back
// and result hand-off.
// ----------------------------------------------------------------------------
module ssol_ctrl
  import ssol_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  state_t             state;
  logic [WORD_AW-1:0] cnt;
  logic               sweep_last;

  assign sweep_last = cnt[WSEL_W-1:0] == WSEL_W'(WORDS_PER_SPAN - 1);

  always_comb begin
    cmd           = '0;
    cmd.wipe_idx  = cnt;
    cmd.load      = state == ST_IDLE && in_valid;
    cmd.wipe      = state == ST_CLEAR || state == ST_SWEEP;
    cmd.wipe_span = state == ST_SWEEP;
    cmd.commit    = (state == ST_EXEC && !status.recycle_ok) ||
                    (state == ST_SWEEP && sweep_last);
    cmd.out_load  = status.out_free &&
                    ((state == ST_EXEC && !status.recycle_ok) ||
                     (state == ST_SWEEP && sweep_last) || state == ST_HOLD);
  end

  assign in_stall = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + WORD_AW'(1);
          if (cnt == WORD_AW'(TOTAL_WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          cnt <= '0;
          if (in_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (status.recycle_ok) state <= ST_SWEEP;
          else if (status.out_free) state <= ST_IDLE;
          else state <= ST_HOLD;
        end
        ST_SWEEP: begin
          cnt <= cnt + WORD_AW'(1);
          if (sweep_last) state <= status.out_free ? ST_IDLE : ST_HOLD;
        end
        ST_HOLD: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/span_slot_ownership_ledger_unit.sv
// ----------------------------------------------------------------------------
// Span slot ownership ledger
// Per-span slot bitmap, owner binding and counters for an allocator.
//
//   channel  handshake            beat
//   in       in_valid/in_stall    opcode, span, slot, class, token, shadow,
//                                 capacity, batch_end
//   out      out_valid/out_stall  accepted, span record fields, flags,
//                                 last_of_batch
//
// Each item has a read step, which reads the span record and bitmap word
// from their memories, and a write-back step; no new item is taken until
// the write-back is done. Recycle with a matching owner runs the read step,
// an evaluate step, then sweep steps that zero one bitmap word of the span
// each, the last also writing the record. After rst a clearing pass zeroes
// the bitmap and records with in_stall high.
// A finished result waits in the output register while the next item is
// taken; only a second result held behind a stalled output blocks input.
// ----------------------------------------------------------------------------
module span_slot_ownership_ledger_unit
  import ssol_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   opcode,
  input  logic [SPAN_W-1:0] span_index,
  input  logic [SLOT_W-1:0] slot_number,
  input  logic [CLS_W-1:0]  size_class,
  input  logic [TOK_W-1:0]  owner_slot,
  input  logic [CNT_W-1:0]  owner_generation,
  input  logic              shadow_present,
  input  logic [TOK_W-1:0]  shadow_slot,
  input  logic [CNT_W-1:0]  shadow_generation,
  input  logic [CAP_W-1:0]  class_capacity,
  input  logic              batch_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              accepted,
  output logic [CAP_W-1:0]  carved_count,
  output logic [CAP_W-1:0]  outstanding_count,
  output logic [CNT_W-1:0]  drained_count,
  output logic [CNT_W-1:0]  rejected_count,
  output logic [TOK_W-1:0]  bound_owner_slot,
  output logic [CNT_W-1:0]  bound_owner_generation,
  output logic [CLS_W-1:0]  bound_class,
  output logic              span_full,
  output logic              reuse_candidate,
  output logic              last_of_batch
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  ssol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssol_datapath u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .status                 (status),
    .opcode                 (opcode),
    .span_index             (span_index),
    .slot_number            (slot_number),
    .size_class             (size_class),
    .owner_slot             (owner_slot),
    .owner_generation       (owner_generation),
    .shadow_present         (shadow_present),
    .shadow_slot            (shadow_slot),
    .shadow_generation      (shadow_generation),
    .class_capacity         (class_capacity),
    .batch_end              (batch_end),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .accepted               (accepted),
    .carved_count           (carved_count),
    .outstanding_count      (outstanding_count),
    .drained_count          (drained_count),
    .rejected_count         (rejected_count),
    .bound_owner_slot       (bound_owner_slot),
    .bound_owner_generation (bound_owner_generation),
    .bound_class            (bound_class),
    .span_full              (span_full),
    .reuse_candidate        (reuse_candidate),
    .last_of_batch          (last_of_batch)
  );

endmodule

// File: bench/span_slot_ownership_ledger_unit_tb.sv
// ----------------------------------------------------------------------------
// Span slot ownership ledger testbench
// Drives acquire, drain, return, query and recycle beats into the ledger and
// predicts every result from a private copy of the span records and slot
// bitmaps. Covers directed corner cases, random traffic built around planned
// span owners, output back-pressure that fills the block, and idle phases.
// ----------------------------------------------------------------------------
module span_slot_ownership_ledger_unit_tb;
  import ssol_pkg::*;

  localparam logic [OP_W-1:0]  OP_LAST      = '1;
  localparam logic [CLS_W-1:0] CLASS_NO_TAG = '1;   // tag wraps to zero
  localparam logic [TOK_W-1:0] TOK_A_SLOT   = '1;
  localparam logic [CNT_W-1:0] TOK_A_GEN    = '1;
  localparam logic [TOK_W-1:0] TOK_B_SLOT   = '0;
  localparam logic [CNT_W-1:0] TOK_B_GEN    = '0;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SPAN_W-1:0] span_index;
    logic [SLOT_W-1:0] slot_number;
    logic [CLS_W-1:0]  size_class;
    logic [TOK_W-1:0]  owner_slot;
    logic [CNT_W-1:0]  owner_generation;
    logic              shadow_present;
    logic [TOK_W-1:0]  shadow_slot;
    logic [CNT_W-1:0]  shadow_generation;
    logic [CAP_W-1:0]  class_capacity;
    logic              batch_end;
  } ledger_req_t;

  typedef struct packed {
    logic              accepted;
    logic [CAP_W-1:0]  carved_count;
    logic [CAP_W-1:0]  outstanding_count;
    logic [CNT_W-1:0]  drained_count;
    logic [CNT_W-1:0]  rejected_count;
    logic [TOK_W-1:0]  bound_owner_slot;
    logic [CNT_W-1:0]  bound_owner_generation;
    logic [CLS_W-1:0]  bound_class;
    logic              span_full;
    logic              reuse_candidate;
    logic              last_of_batch;
  } ledger_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   opcode = '0;
  logic [SPAN_W-1:0] span_index = '0;
  logic [SLOT_W-1:0] slot_number = '0;
  logic [CLS_W-1:0]  size_class = '0;
  logic [TOK_W-1:0]  owner_slot = '0;
  logic [CNT_W-1:0]  owner_generation = '0;
  logic              shadow_present = 1'b0;
  logic [TOK_W-1:0]  shadow_slot = '0;
  logic [CNT_W-1:0]  shadow_generation = '0;
  logic [CAP_W-1:0]  class_capacity = '0;
  logic              batch_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              accepted;
  logic [CAP_W-1:0]  carved_count;
  logic [CAP_W-1:0]  outstanding_count;
  logic [CNT_W-1:0]  drained_count;
  logic [CNT_W-1:0]  rejected_count;
  logic [TOK_W-1:0]  bound_owner_slot;
  logic [CNT_W-1:0]  bound_owner_generation;
  logic [CLS_W-1:0]  bound_class;
  logic              span_full;
  logic              reuse_candidate;
  logic              last_of_batch;

  span_slot_ownership_ledger_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .span_index(span_index), .slot_number(slot_number),
    .size_class(size_class), .owner_slot(owner_slot),
    .owner_generation(owner_generation), .shadow_present(shadow_present),
    .shadow_slot(shadow_slot), .shadow_generation(shadow_generation),
    .class_capacity(class_capacity), .batch_end(batch_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .carved_count(carved_count),
    .outstanding_count(outstanding_count), .drained_count(drained_count),
    .rejected_count(rejected_count), .bound_owner_slot(bound_owner_slot),
    .bound_owner_generation(bound_owner_generation), .bound_class(bound_class),
    .span_full(span_full), .reuse_candidate(reuse_candidate),
    .last_of_batch(last_of_batch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ledger copy kept by the predictor
  logic [MAX_SLOTS-1:0] slot_map      [SPAN_COUNT];
  logic [TOK_W-1:0]     span_tok_slot [SPAN_COUNT];
  logic [CNT_W-1:0]     span_tok_gen  [SPAN_COUNT];
  logic [CLS_W-1:0]     span_tag      [SPAN_COUNT];
  logic [CAP_W-1:0]     span_cap      [SPAN_COUNT];
  logic [CAP_W-1:0]     span_carved   [SPAN_COUNT];
  logic [CAP_W-1:0]     span_out      [SPAN_COUNT];
  logic [CNT_W-1:0]     span_drains   [SPAN_COUNT];
  logic [CNT_W-1:0]     span_rejects  [SPAN_COUNT];

  // owner the stimulus intends for each span
  logic [TOK_W-1:0]     plan_slot  [SPAN_COUNT];
  logic [CNT_W-1:0]     plan_gen   [SPAN_COUNT];
  logic [CLS_W-1:0]     plan_class [SPAN_COUNT];
  logic [CAP_W-1:0]     plan_cap   [SPAN_COUNT];

  ledger_result_t pending_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int mismatches    = 0;

  function automatic bit owner_admits(ledger_req_t r, bit shadow_ok);
    logic [CLS_W-1:0] tag;
    tag = r.size_class + 1'b1;
    if (!shadow_ok) return 1'b0;
    if (span_tag[r.span_index] == '0) begin
      span_tok_slot[r.span_index] = r.owner_slot;
      span_tok_gen[r.span_index]  = r.owner_generation;
      span_tag[r.span_index]      = tag;
      span_cap[r.span_index]      = r.class_capacity;
      return 1'b1;
    end
    return span_tok_slot[r.span_index] == r.owner_slot &&
           span_tok_gen[r.span_index] == r.owner_generation &&
           span_tag[r.span_index] == tag;
  endfunction

  function automatic ledger_result_t predict_ledger(ledger_req_t r);
    ledger_result_t res;
    bit shadow_ok;
    bit hit;
    bit full;
    int unsigned sp;
    logic [CAP_W-1:0] top;
    res = '0;
    res.last_of_batch = r.batch_end;
    sp = 32'(r.span_index);
    shadow_ok = r.shadow_present && r.shadow_slot == r.owner_slot &&
                r.shadow_generation == r.owner_generation;
    hit = slot_map[sp][r.slot_number];
    top = {1'b0, r.slot_number} + 1'b1;
    case (r.opcode)
      OP_QUERY: begin
        if (span_tag[sp] != '0) begin
          full = span_cap[sp] != '0 && span_carved[sp] == span_cap[sp];
          res.accepted               = 1'b1;
          res.carved_count           = span_carved[sp];
          res.outstanding_count      = span_out[sp];
          res.drained_count          = span_drains[sp];
          res.rejected_count         = span_rejects[sp];
          res.bound_owner_slot       = span_tok_slot[sp];
          res.bound_owner_generation = span_tok_gen[sp];
          res.bound_class            = span_tag[sp] - 1'b1;
          res.span_full              = full;
          res.reuse_candidate        = full && span_out[sp] == '0 && span_rejects[sp] == '0;
        end
      end
      OP_ACQUIRE: begin
        if (!owner_admits(r, shadow_ok) || hit) begin
          span_rejects[sp] += 1;
        end else begin
          slot_map[sp][r.slot_number] = 1'b1;
          if (span_carved[sp] < top) span_carved[sp] = top;
          span_out[sp] += CAP_W'(1);
          res.accepted = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (!owner_admits(r, shadow_ok) || !hit) begin
          span_rejects[sp] += 1;
        end else begin
          span_drains[sp] += 1;
          res.accepted = 1'b1;
        end
      end
      OP_RETURN: begin
        if (!owner_admits(r, shadow_ok) || !hit || span_out[sp] == '0) begin
          span_rejects[sp] += 1;
        end else begin
          slot_map[sp][r.slot_number] = 1'b0;
          span_out[sp] -= CAP_W'(1);
          res.accepted = 1'b1;
        end
      end
      OP_RECYCLE: begin
        if (shadow_ok) begin
          slot_map[sp]      = '0;
          span_carved[sp]   = '0;
          span_out[sp]      = '0;
          span_drains[sp]   = '0;
          span_rejects[sp]  = '0;
          span_tok_slot[sp] = r.owner_slot;
          span_tok_gen[sp]  = r.owner_generation;
          span_tag[sp]      = r.size_class + 1'b1;
          span_cap[sp]      = r.class_capacity;
          res.accepted      = 1'b1;
        end
      end
      default: ;   // unknown opcodes leave the ledger alone
    endcase
    return res;
  endfunction

  function automatic ledger_req_t owned_req(logic [OP_W-1:0] op, logic [SPAN_W-1:0] sp,
                                            logic [SLOT_W-1:0] slot, logic [CLS_W-1:0] cls,
                                            logic [TOK_W-1:0] tok, logic [CNT_W-1:0] gen,
                                            logic [CAP_W-1:0] cap);
    ledger_req_t r;
    r.opcode            = op;
    r.span_index        = sp;
    r.slot_number       = slot;
    r.size_class        = cls;
    r.owner_slot        = tok;
    r.owner_generation  = gen;
    r.shadow_present    = 1'b1;
    r.shadow_slot       = tok;
    r.shadow_generation = gen;
    r.class_capacity    = cap;
    r.batch_end         = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic void replan_span(int unsigned sp);
    int unsigned roll;
    roll = $urandom_range(99);
    plan_slot[sp] = TOK_W'($urandom);
    plan_gen[sp]  = $urandom;
    if (roll < 5)       plan_class[sp] = CLASS_NO_TAG;
    else if (roll < 10) plan_class[sp] = CLASS_NO_TAG - 1'b1;
    else                plan_class[sp] = CLS_W'($urandom_range(253));
    roll = $urandom_range(99);
    if (roll < 60)      plan_cap[sp] = CAP_W'($urandom_range(6, 1));
    else if (roll < 70) plan_cap[sp] = CAP_W'(MAX_SLOTS);
    else if (roll < 85) plan_cap[sp] = CAP_W'($urandom_range(MAX_SLOTS, 7));
    else                plan_cap[sp] = CAP_W'($urandom);   // zero and oversize too
  endfunction

  // mostly well-formed traffic on a few hot spans, with owner/class noise
  function automatic ledger_req_t random_req();
    ledger_req_t r;
    int unsigned pick;
    int unsigned sp;
    int unsigned lim;
    pick = $urandom_range(99);
    sp = ($urandom_range(99) < 75) ? $urandom_range(7) * 9 : $urandom_range(SPAN_COUNT - 1);
    if (pick >= 95 && pick < 98) replan_span(sp);
    lim = (plan_cap[sp] == '0 || plan_cap[sp] > MAX_SLOTS) ? MAX_SLOTS - 1 : plan_cap[sp] - 1;
    r = owned_req(OP_ACQUIRE, SPAN_W'(sp), SLOT_W'($urandom_range(lim)), plan_class[sp],
                  plan_slot[sp], plan_gen[sp], plan_cap[sp]);
    if (pick < 40)      r.opcode = OP_ACQUIRE;
    else if (pick < 53) r.opcode = OP_DRAIN;
    else if (pick < 75) r.opcode = OP_RETURN;
    else if (pick < 95) r.opcode = OP_QUERY;
    else if (pick < 98) r.opcode = OP_RECYCLE;
    else                r.opcode = OP_W'($urandom_range(OP_LAST, OP_RECYCLE + 1));
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(4))
        0: r.shadow_present = 1'b0;
        1: r.shadow_slot = TOK_W'($urandom);
        2: r.shadow_generation = $urandom;
        3: r.size_class = CLS_W'($urandom);
        default: begin
          // foreign owner with a consistent shadow
          r.owner_slot        = TOK_W'($urandom);
          r.owner_generation  = $urandom;
          r.shadow_slot       = r.owner_slot;
          r.shadow_generation = r.owner_generation;
        end
      endcase
    end
    if (r.opcode == OP_QUERY) begin
      r.slot_number       = SLOT_W'($urandom);
      r.size_class        = CLS_W'($urandom);
      r.shadow_generation = $urandom;
      r.class_capacity    = CAP_W'($urandom);
    end
    return r;
  endfunction

  task automatic send_req(input ledger_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    opcode            <= r.opcode;
    span_index        <= r.span_index;
    slot_number       <= r.slot_number;
    size_class        <= r.size_class;
    owner_slot        <= r.owner_slot;
    owner_generation  <= r.owner_generation;
    shadow_present    <= r.shadow_present;
    shadow_slot       <= r.shadow_slot;
    shadow_generation <= r.shadow_generation;
    class_capacity    <= r.class_capacity;
    batch_end         <= r.batch_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_ledger(r));
  endtask

  // always advances at least one edge so in_valid never gets two updates
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    ledger_req_t r;
    send_req(owned_req(OP_QUERY, 6'd63, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    // absent shadow rejects even on an unbound span
    r = owned_req(OP_ACQUIRE, 6'd63, 9'd511, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd512);
    r.shadow_present = 1'b0;
    send_req(r);
    r.shadow_present = 1'b1;
    send_req(r);
    send_req(r);    // slot already outstanding
    send_req(owned_req(OP_ACQUIRE, 6'd63, 9'd0, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd3));
    send_req(owned_req(OP_DRAIN, 6'd63, 9'd511, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    send_req(owned_req(OP_DRAIN, 6'd63, 9'd1, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    r = owned_req(OP_DRAIN, 6'd63, 9'd0, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd0);
    r.shadow_generation[0] = 1'b0;
    send_req(r);
    send_req(owned_req(OP_RETURN, 6'd63, 9'd0, 8'd253, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    send_req(owned_req(OP_RETURN, 6'd63, 9'd0, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    send_req(owned_req(OP_RETURN, 6'd63, 9'd0, 8'd254, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    send_req(owned_req(OP_QUERY, 6'd63, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    // failed recycle counts no rejection
    r = owned_req(OP_RECYCLE, 6'd63, 9'd0, 8'd0, TOK_B_SLOT, TOK_B_GEN, 10'd1);
    r.shadow_slot = 8'h01;
    send_req(r);
    r.shadow_slot = TOK_B_SLOT;
    send_req(r);
    send_req(owned_req(OP_ACQUIRE, 6'd63, 9'd0, 8'd0, TOK_B_SLOT, TOK_B_GEN, 10'd9));
    send_req(owned_req(OP_QUERY, 6'd63, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    send_req(owned_req(OP_RETURN, 6'd63, 9'd0, 8'd0, TOK_B_SLOT, TOK_B_GEN, 10'd0));
    send_req(owned_req(OP_QUERY, 6'd63, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    // class whose tag wraps leaves the span unbound
    send_req(owned_req(OP_ACQUIRE, 6'd1, 9'd4, CLASS_NO_TAG, TOK_A_SLOT, TOK_A_GEN, 10'd7));
    send_req(owned_req(OP_QUERY, 6'd1, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    send_req(owned_req(OP_RECYCLE, 6'd2, 9'd0, CLASS_NO_TAG, TOK_B_SLOT, TOK_B_GEN, 10'd5));
    for (int op = OP_RECYCLE + 1; op <= OP_LAST; op++)
      send_req(owned_req(OP_W'(op), 6'd63, 9'd0, 8'd0, TOK_B_SLOT, TOK_B_GEN, 10'd0));
    // zero capacity never reports full
    send_req(owned_req(OP_RECYCLE, 6'd63, 9'd0, 8'd7, TOK_A_SLOT, TOK_A_GEN, 10'd0));
    send_req(owned_req(OP_QUERY, 6'd63, 9'd0, 8'd0, 8'd0, 32'd0, 10'd0));
    wait_for_results();
  endtask

  task automatic test_random(input int count, input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) send_req(random_req());
    wait_for_results();
  endtask

  // long output hold-off while beats keep coming, then a full drain
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 300;
    repeat (40) send_req(random_req());
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag_field(input string what, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    ledger_result_t want;
    ledger_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {accepted, carved_count, outstanding_count, drained_count, rejected_count,
             bound_owner_slot, bound_owner_generation, bound_class, span_full,
             reuse_candidate, last_of_batch};
      if (pending_results.size() == 0) begin
        flag_field("beat with no pending result", '0, CNT_W'(got.accepted));
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted)
          flag_field("accepted", CNT_W'(want.accepted), CNT_W'(got.accepted));
        if (got.carved_count !== want.carved_count)
          flag_field("carved_count", CNT_W'(want.carved_count), CNT_W'(got.carved_count));
        if (got.outstanding_count !== want.outstanding_count)
          flag_field("outstanding_count", CNT_W'(want.outstanding_count),
                     CNT_W'(got.outstanding_count));
        if (got.drained_count !== want.drained_count)
          flag_field("drained_count", want.drained_count, got.drained_count);
        if (got.rejected_count !== want.rejected_count)
          flag_field("rejected_count", want.rejected_count, got.rejected_count);
        if (got.bound_owner_slot !== want.bound_owner_slot)
          flag_field("bound_owner_slot", CNT_W'(want.bound_owner_slot),
                     CNT_W'(got.bound_owner_slot));
        if (got.bound_owner_generation !== want.bound_owner_generation)
          flag_field("bound_owner_generation", want.bound_owner_generation,
                     got.bound_owner_generation);
        if (got.bound_class !== want.bound_class)
          flag_field("bound_class", CNT_W'(want.bound_class), CNT_W'(got.bound_class));
        if (got.span_full !== want.span_full)
          flag_field("span_full", CNT_W'(want.span_full), CNT_W'(got.span_full));
        if (got.reuse_candidate !== want.reuse_candidate)
          flag_field("reuse_candidate", CNT_W'(want.reuse_candidate),
                     CNT_W'(got.reuse_candidate));
        if (got.last_of_batch !== want.last_of_batch)
          flag_field("last_of_batch", CNT_W'(want.last_of_batch), CNT_W'(got.last_of_batch));
      end
    end
  end

  initial begin
    for (int sp = 0; sp < SPAN_COUNT; sp++) begin
      slot_map[sp]      = '0;
      span_tok_slot[sp] = '0;
      span_tok_gen[sp]  = '0;
      span_tag[sp]      = '0;
      span_cap[sp]      = '0;
      span_carved[sp]   = '0;
      span_out[sp]      = '0;
      span_drains[sp]   = '0;
      span_rejects[sp]  = '0;
      replan_span(sp);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 45;
    test_directed();
    test_random(700, 21, 45);
    test_backpressure();
    test_random(700, 45, 21);
    test_random(600, 0, 0);
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: span_slot_ownership_ledger_unit.f
hw/rtl/ssol_pkg.sv
hw/rtl/ssol_datapath.sv
hw/rtl/ssol_ctrl.sv
hw/rtl/span_slot_ownership_ledger_unit.sv
bench/span_slot_ownership_ledger_unit_tb.sv
